@@ hdl/ecpr_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ecpr_pkg
// Shared types, codes and default sizes for the enhanced clock replacement core.
// -----------------------------------------------------------------------------
package ecpr_pkg;

    // default sizes
    localparam int FRAMES_DEF   = 64;
    localparam int TAG_BITS_DEF = 20;

    // fixed port widths
    localparam int KIND_W     = 2;
    localparam int FRAME_IN_W = 6;
    localparam int TAG_IN_W   = 20;
    localparam int CFG_W      = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PLACE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REF    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd3;

    // scan operations of the evaluation unit
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_REF    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SWEEP  = 2'd2;

    localparam int SWEEPS = 4;
    localparam logic [1:0] LAST_SWEEP = 2'(SWEEPS - 1);

    // verdict on one frame entry
    typedef struct packed {
        logic hit;
        logic wr;
        logic occ_n;
        logic used_n;
        logic dirty_n;
    } t_eval;

endpackage

@@ hdl/ecpr_ram.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ecpr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module ecpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/ecpr_eval.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ecpr_eval
// Shared frame evaluation unit: tag match for lookups, use/dirty class test
// for the victim sweeps, and the updated status bits to write back.
// -----------------------------------------------------------------------------
module ecpr_eval #(
    parameter int TAG_BITS = ecpr_pkg::TAG_BITS_DEF
) (
    input  logic [ecpr_pkg::OP_W-1:0] i_op,
    input  logic                      i_want_dirty,
    input  logic                      i_modified,
    input  logic [TAG_BITS-1:0]       i_key_tag,
    input  logic                      i_occ,
    input  logic                      i_used,
    input  logic                      i_dirty,
    input  logic [TAG_BITS-1:0]       i_tag,
    output ecpr_pkg::t_eval           o_eval
);

    logic tag_hit;

    assign tag_hit = i_occ && (i_tag == i_key_tag);

    always_comb begin
        o_eval.hit     = 1'b0;
        o_eval.wr      = 1'b0;
        o_eval.occ_n   = i_occ;
        o_eval.used_n  = i_used;
        o_eval.dirty_n = i_dirty;
        case (i_op)
            ecpr_pkg::OP_REF: begin
                o_eval.hit     = tag_hit;
                o_eval.wr      = tag_hit;
                o_eval.used_n  = 1'b1;
                o_eval.dirty_n = i_dirty | i_modified;
            end
            ecpr_pkg::OP_REMOVE: begin
                o_eval.hit     = tag_hit;
                o_eval.wr      = tag_hit;
                o_eval.occ_n   = 1'b0;
                o_eval.used_n  = 1'b0;
                o_eval.dirty_n = 1'b0;
            end
            ecpr_pkg::OP_SWEEP: begin
                o_eval.hit    = i_occ && !i_used && (i_dirty == i_want_dirty);
                // second-chance sweeps take the use bit away from non-matches
                o_eval.wr     = i_occ && !o_eval.hit && i_want_dirty;
                o_eval.used_n = 1'b0;
            end
            default: begin
                o_eval.hit = 1'b0;
                o_eval.wr  = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/enhanced_clock_page_replacement_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// enhanced_clock_page_replacement_core
// Enhanced second-chance clock replacement over one pool of frames. Frame state
// (occupied, use, dirty, tag) sits in one RAM; a sequencer walks it one frame
// at a time through a shared evaluation unit.
// -----------------------------------------------------------------------------
//  channel | direction | handshake               | beat
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (frames_in_use)
//  in      | in        | i_in_valid/o_in_ready   | kind, frame, page_tag, modified
//  out     | out       | o_out_valid/i_out_ready | found, frame_index, victim_tag,
//          |           |                         | victim_dirty
//
// Place: the request goes from accept straight to S_DONE. Reference/remove:
// examine up to count frames. Victim: examine up to 4 * count frames.
// Each examined frame passes a RAM read state (S_RD) and an evaluate/write
// state (S_EV). After reset a clearing pass over all FRAMES frames runs before
// o_in_ready rises. One item at a time; a finished result waits in the output
// register while the next item is accepted.
// -----------------------------------------------------------------------------
module enhanced_clock_page_replacement_core #(
    parameter int FRAMES   = ecpr_pkg::FRAMES_DEF,
    parameter int TAG_BITS = ecpr_pkg::TAG_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ecpr_pkg::CFG_W-1:0]      i_cfg_data,
    // request
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ecpr_pkg::KIND_W-1:0]     i_kind,
    input  logic [ecpr_pkg::FRAME_IN_W-1:0] i_frame,
    input  logic [ecpr_pkg::TAG_IN_W-1:0]   i_page_tag,
    input  logic                            i_modified,
    // result
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [ecpr_pkg::FRAME_IN_W-1:0] o_frame_index,
    output logic [ecpr_pkg::TAG_IN_W-1:0]   o_victim_tag,
    output logic                            o_victim_dirty
);

    localparam int FRAME_W = $clog2(FRAMES);
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int WORD_W  = TAG_BITS + 3;
    localparam int OCC_B   = TAG_BITS + 2;
    localparam int USED_B  = TAG_BITS + 1;
    localparam int DIRTY_B = TAG_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EV    = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [ecpr_pkg::CFG_W-1:0]  r_cfg;
    logic [FRAME_W-1:0]          r_hand, n_hand;
    logic [FRAME_W-1:0]          r_ptr, n_ptr;
    logic [CNT_W-1:0]            r_step, n_step;
    logic [1:0]                  r_sweep, n_sweep;
    logic [ecpr_pkg::OP_W-1:0]   r_op, n_op;
    logic [TAG_BITS-1:0]         r_key, n_key;
    logic                        r_mod, n_mod;
    logic                        r_res_found, n_res_found;
    logic [FRAME_W-1:0]          r_res_idx, n_res_idx;
    logic [TAG_BITS-1:0]         r_res_tag, n_res_tag;
    logic                        r_res_dirty, n_res_dirty;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [ecpr_pkg::FRAME_IN_W-1:0] r_out_idx;
    logic [ecpr_pkg::TAG_IN_W-1:0]   r_out_tag;
    logic                        r_out_dirty;

    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   ptr_inc;
    logic [FRAME_W-1:0] ptr_next;
    logic               in_acc;
    logic               place_ok;
    logic               out_load;

    logic               ram_we;
    logic [FRAME_W-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [WORD_W-1:0]  ram_rdata;

    ecpr_pkg::t_eval    ev;

    // managed count: zero acts as one, clipped to the pool size
    always_comb begin
        if (r_cfg == '0) begin
            count = CNT_W'(1);
        end else if (32'(r_cfg) > FRAMES) begin
            count = CNT_W'(FRAMES);
        end else begin
            count = CNT_W'(r_cfg);
        end
    end

    assign ptr_inc  = CNT_W'(r_ptr) + CNT_W'(1);
    assign ptr_next = (ptr_inc >= count) ? '0 : r_ptr[FRAME_W-1:0] + FRAME_W'(1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign place_ok    = (32'(i_frame) < 32'(count));
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    ecpr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAMES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_ptr),
        .o_rd_data (ram_rdata)
    );

    ecpr_eval #(
        .TAG_BITS (TAG_BITS)
    ) u_eval (
        .i_op         (r_op),
        .i_want_dirty (r_sweep[0]),
        .i_modified   (r_mod),
        .i_key_tag    (r_key),
        .i_occ        (ram_rdata[OCC_B]),
        .i_used       (ram_rdata[USED_B]),
        .i_dirty      (ram_rdata[DIRTY_B]),
        .i_tag        (ram_rdata[TAG_BITS-1:0]),
        .o_eval       (ev)
    );

    assign ram_re = (r_state == S_RD);

    // RAM write port: clearing pass, place, or write-back after evaluation
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (in_acc && (i_kind == ecpr_pkg::KIND_PLACE) && place_ok) begin
            ram_we    = 1'b1;
            ram_waddr = FRAME_W'(i_frame);
            ram_wdata = {1'b1, 1'b1, i_modified, TAG_BITS'(i_page_tag)};
        end else if ((r_state == S_EV) && ev.wr) begin
            ram_we    = 1'b1;
            ram_wdata = {ev.occ_n, ev.used_n, ev.dirty_n, ram_rdata[TAG_BITS-1:0]};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_hand      = r_hand;
        n_ptr       = r_ptr;
        n_step      = r_step;
        n_sweep     = r_sweep;
        n_op        = r_op;
        n_key       = r_key;
        n_mod       = r_mod;
        n_res_found = r_res_found;
        n_res_idx   = r_res_idx;
        n_res_tag   = r_res_tag;
        n_res_dirty = r_res_dirty;
        case (r_state)
            S_CLEAR: begin
                n_ptr = r_ptr + FRAME_W'(1);
                if (r_ptr == FRAME_W'(FRAMES - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_key       = TAG_BITS'(i_page_tag);
                    n_mod       = i_modified;
                    n_step      = '0;
                    n_sweep     = '0;
                    n_res_found = 1'b0;
                    n_res_idx   = '0;
                    n_res_tag   = '0;
                    n_res_dirty = 1'b0;
                    case (i_kind)
                        ecpr_pkg::KIND_PLACE: begin
                            n_state = S_DONE;
                            if (place_ok) begin
                                n_res_found = 1'b1;
                                n_res_idx   = FRAME_W'(i_frame);
                            end
                        end
                        ecpr_pkg::KIND_REF: begin
                            n_op    = ecpr_pkg::OP_REF;
                            n_ptr   = '0;
                            n_state = S_RD;
                        end
                        ecpr_pkg::KIND_REMOVE: begin
                            n_op    = ecpr_pkg::OP_REMOVE;
                            n_ptr   = '0;
                            n_state = S_RD;
                        end
                        default: begin
                            n_op    = ecpr_pkg::OP_SWEEP;
                            // a hand left beyond a shrunk count restarts at frame 0
                            n_ptr   = (CNT_W'(r_hand) >= count) ? '0 : r_hand;
                            n_state = S_RD;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                n_ptr = ptr_next;
                if (ev.hit) begin
                    n_res_found = 1'b1;
                    n_res_idx   = r_ptr;
                    n_state     = S_DONE;
                    if (r_op == ecpr_pkg::OP_SWEEP) begin
                        n_res_tag   = ram_rdata[TAG_BITS-1:0];
                        n_res_dirty = ram_rdata[DIRTY_B];
                        n_hand      = ptr_next;
                    end
                end else if ((r_step + CNT_W'(1)) == count) begin
                    n_step = '0;
                    if (r_op != ecpr_pkg::OP_SWEEP) begin
                        n_state = S_DONE;
                    end else if (r_sweep == ecpr_pkg::LAST_SWEEP) begin
                        n_hand  = ptr_next;
                        n_state = S_DONE;
                    end else begin
                        n_sweep = r_sweep + 2'd1;
                        n_state = S_RD;
                    end
                end else begin
                    n_step  = r_step + CNT_W'(1);
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg       <= ecpr_pkg::CFG_RESET;
            r_hand      <= '0;
            r_ptr       <= '0;
            r_step      <= '0;
            r_sweep     <= '0;
            r_op        <= ecpr_pkg::OP_REF;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hand  <= n_hand;
            r_ptr   <= n_ptr;
            r_step  <= n_step;
            r_sweep <= n_sweep;
            r_op    <= n_op;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_mod       <= n_mod;
        r_res_found <= n_res_found;
        r_res_idx   <= n_res_idx;
        r_res_tag   <= n_res_tag;
        r_res_dirty <= n_res_dirty;
        if (out_load) begin
            r_out_found <= r_res_found;
            r_out_idx   <= ecpr_pkg::FRAME_IN_W'(r_res_idx);
            r_out_tag   <= ecpr_pkg::TAG_IN_W'(r_res_tag);
            r_out_dirty <= r_res_dirty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_frame_index  = r_out_idx;
    assign o_victim_tag   = r_out_tag;
    assign o_victim_dirty = r_out_dirty;

endmodule

@@ hdl/ecpr_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ecpr_checker
// Port-level checks on the clock replacement core, bound to the top level.
// -----------------------------------------------------------------------------
module ecpr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_found,
    input logic [ecpr_pkg::FRAME_IN_W-1:0] o_frame_index,
    input logic [ecpr_pkg::TAG_IN_W-1:0]   o_victim_tag,
    input logic                            o_victim_dirty
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_found) && $stable(o_frame_index) &&
            $stable(o_victim_tag) && $stable(o_victim_dirty))
        else $error("result beat changed while stalled");

    // one item at a time: ready drops after an accepted request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

    // a miss carries no frame, tag or dirty flag
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |->
            o_frame_index == '0 && o_victim_tag == '0 && !o_victim_dirty)
        else $error("miss result with nonzero payload");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("activity right after reset");

endmodule

bind enhanced_clock_page_replacement_core ecpr_checker u_ecpr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_found        (o_found),
    .o_frame_index  (o_frame_index),
    .o_victim_tag   (o_victim_tag),
    .o_victim_dirty (o_victim_dirty)
);
